### rtl/core/radix_base_converter_top_assert.svh
// Assertion macros for the radix base converter.
// Included by radix_base_converter_top.sv; no other dependencies.
`ifndef RADIX_BASE_CONVERTER_TOP_ASSERT_SVH
`define RADIX_BASE_CONVERTER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising clock edge outside reset.
`define RBC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("radix_base_converter: assertion failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define RBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("radix_base_converter: assertion failed");
`else
`define RBC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RBC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/core/rbc_pkg.sv
// Shared constants, register indexes and digit helper functions for the
// radix base converter. No dependencies.
package rbc_pkg;

  localparam int ACC_W      = 64;               // accumulator width
  localparam int BASE_W     = 5;                // width of a base register
  localparam int DIG_W      = 4;                // width of one digit value
  localparam int CHAR_W     = 8;                // width of an ASCII character
  localparam int MAX_DIGITS = 64;               // digits kept per conversion
  localparam int ADDR_W     = $clog2(MAX_DIGITS);
  localparam int CNT_W      = 7;                // digit count width
  localparam int DIV_BITS   = 8;                // quotient bits per divider cycle
  localparam int DIV_STEPS  = ACC_W / DIV_BITS; // divider steps per digit
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SRC_BASE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DST_BASE = CFG_IDX_W'(1);

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_MIN   = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(16);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30; // '0'
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39; // '9'
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61; // 'a'
  localparam logic [CHAR_W-1:0] CHAR_F     = 8'h66; // 'f'

  // Value of an incoming digit character; anything foreign counts as zero.
  function automatic logic [DIG_W-1:0] char_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    begin
      d = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        d = c - CHAR_ZERO;
      end else if (c >= CHAR_A && c <= CHAR_F) begin
        d = c - CHAR_A + CHAR_W'(10);
      end
      return d[DIG_W-1:0];
    end
  endfunction

  // Lower-case ASCII character of a digit value.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] c;
    begin
      if (d < DIG_W'(10)) begin
        c = CHAR_ZERO + CHAR_W'(d);
      end else begin
        c = CHAR_A + CHAR_W'(d) - CHAR_W'(10);
      end
      return c;
    end
  endfunction

endpackage

### rtl/core/rbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rbc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/rbc_div_unit.sv
// Iterative divider of a 64-bit value by a small base (2 to 16), several
// quotient bits per cycle. Depends on rbc_pkg.
module rbc_div_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rbc_pkg::ACC_W-1:0] dividend,
  input  logic [rbc_pkg::BASE_W-1:0] base,
  output logic                      done,
  output logic [rbc_pkg::ACC_W-1:0] quotient,
  output logic [rbc_pkg::DIG_W-1:0] remainder
);
  import rbc_pkg::*;

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic [ACC_W-1:0]    work;
  logic [BASE_W-1:0]   rem;
  logic [BASE_W-1:0]   base_r;
  logic [ACC_W-1:0]    work_next;
  logic [BASE_W-1:0]   rem_next;

  // One restoring step per dividend bit, DIV_BITS steps per cycle. The
  // partial remainder stays below the base, so it fits in BASE_W bits.
  always_comb begin
    logic [BASE_W-1:0]   r;
    logic [BASE_W-1:0]   t;
    logic [DIV_BITS-1:0] q;
    r = rem;
    q = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {r[BASE_W-2:0], work[ACC_W-1-i]};
      if (t >= base_r) begin
        r = t - base_r;
        q[DIV_BITS-1-i] = 1'b1;
      end else begin
        r = t;
      end
    end
    rem_next  = r;
    work_next = {work[ACC_W-DIV_BITS-1:0], q};
  end

  // Quotient bits shift in from the right as dividend bits leave on the left.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    if (start) begin
      work   <= dividend;
      rem    <= '0;
      base_r <= base;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign quotient  = work;
  assign remainder = rem[DIG_W-1:0];

endmodule

### rtl/core/radix_base_converter_top.sv
// Top level of the radix base converter: stream ports, configuration
// registers, accumulator and conversion sequencer.
// Depends on rbc_pkg, rbc_div_unit, rbc_ram and radix_base_converter_top_assert.svh.
`include "radix_base_converter_top_assert.svh"

// Digit characters are taken one per cycle while the block is idle and folded
// into a 64-bit value (value * src_base + digit, modulo 2^64). The request
// marked tlast starts the conversion: a single divider produces the destination
// digits one after another (a load step, then 8 quotient bits per cycle over the
// 64-bit value), and the first digit is offered only once the last digit has
// been produced. Digits are stored in a 64-entry RAM and sent most significant
// first, one at a time, each through a RAM read, an output load and a transfer
// when the sink is ready, the final one with tlast set.
// The input is not ready from the last character until the final digit has
// been taken. Configuration writes are accepted in every cycle; there is no
// memory clearing pass after reset.
module radix_base_converter_top (
  input  logic                          clk,
  input  logic                          rst,
  // Input characters.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] digit_char
  input  logic                          s_tlast,   // last_digit
  // Output characters.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [7:0] out_char
  output logic                          m_tlast,   // last_out
  // Configuration writes.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbc_pkg::BASE_W-1:0]    cfg_data
);
  import rbc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_LOAD,
    S_SHOW
  } state_t;

  state_t                  state;
  logic [BASE_W-1:0]       src_base;
  logic [BASE_W-1:0]       dst_base;
  logic [BASE_W-1:0]       dst_eff;
  logic [ACC_W-1:0]        acc;
  logic [ACC_W+BASE_W-1:0] acc_prod;
  logic [ACC_W-1:0]        acc_next;
  logic [CNT_W-1:0]        n;
  logic [CNT_W-1:0]        n_next;
  logic [ADDR_W-1:0]       idx;
  logic                    in_req;
  logic                    div_start;
  logic                    div_more;
  logic [ACC_W-1:0]        div_dividend;
  logic                    div_done;
  logic [ACC_W-1:0]        div_quot;
  logic [DIG_W-1:0]        div_rem;
  logic                    ram_we;
  logic [DIG_W-1:0]        ram_rdata;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign in_req    = s_tvalid && s_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      src_base <= BASE_RESET;
      dst_base <= BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SRC_BASE: src_base <= cfg_data;
        REG_DST_BASE: dst_base <= cfg_data;
        default: ;
      endcase
    end
  end

  // Destination base limited to the supported range.
  always_comb begin
    if (dst_base < BASE_MIN) begin
      dst_eff = BASE_MIN;
    end else if (dst_base > BASE_MAX) begin
      dst_eff = BASE_MAX;
    end else begin
      dst_eff = dst_base;
    end
  end

  // Horner step: one narrow multiply and one add per character.
  assign acc_prod = acc * src_base;
  assign acc_next = acc_prod[ACC_W-1:0] + ACC_W'(char_value(s_tdata));

  // Divider is started by the final character and restarted while digits remain.
  assign n_next       = n + CNT_W'(1);
  assign div_more     = (div_quot != '0) && (n_next < CNT_W'(MAX_DIGITS));
  assign ram_we       = (state == S_DIV) && div_done;
  assign div_start    = (in_req && s_tlast) || (ram_we && div_more);
  assign div_dividend = (state == S_IDLE) ? acc_next : div_quot;

  rbc_div_unit u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .base      (dst_eff),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // Digit store, least significant digit at address zero.
  rbc_ram #(
    .WIDTH (DIG_W),
    .DEPTH (MAX_DIGITS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (n[ADDR_W-1:0]),
    .wdata (div_rem),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // Sequencer with accumulator, digit count and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      acc      <= '0;
      n        <= '0;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_req) begin
            if (s_tlast) begin
              acc   <= '0;
              n     <= '0;
              state <= S_DIV;
            end else begin
              acc <= acc_next;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            n <= n_next;
            if (!div_more) begin
              idx   <= n[ADDR_W-1:0];
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          m_tvalid <= 1'b1;
          state    <= S_SHOW;
        end
        S_SHOW: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (m_tlast) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx - ADDR_W'(1);
              state <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output payload, loaded from the RAM read data.
  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      m_tdata <= digit_char(ram_rdata);
      m_tlast <= (idx == '0);
    end
  end

  // Input and output never overlap: one number is handled at a time.
  `RBC_ASSERT_IMPL(a_no_overlap, clk, rst, s_tready, !m_tvalid)
  // The final digit returns the block to accepting characters.
  `RBC_ASSERT_NEXT(a_back_to_idle, clk, rst, m_tvalid && m_tready && m_tlast, s_tready)
  // The divider finishes only while the sequencer waits for it.
  `RBC_ASSERT_IMPL(a_done_in_div, clk, rst, div_done, state == S_DIV)
  // The digit count stays within the store.
  `RBC_ASSERT_IMPL(a_count_range, clk, rst, ram_we, n < CNT_W'(MAX_DIGITS))

endmodule
